[hw/rtl/earliest_free_server_assigner_unit_defines.svh]
// Assertion macros used by the checker file of the server assigner
`ifndef EARLIEST_FREE_SERVER_ASSIGNER_UNIT_DEFINES_SVH
`define EARLIEST_FREE_SERVER_ASSIGNER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is high
`define EFSA_ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset
`define EFSA_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/efsa_pkg.sv]
// Shared field widths, codes and sequencer states of the server assigner
package efsa_pkg;

  localparam int IDX_BITS      = 6;
  localparam int AMT_BITS      = 16;
  localparam int OUT_TIME_BITS = 48;
  localparam int CNT_BITS      = 7;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_CUST = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_TOP  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_UP   = 8'b0001_0000,
    S_DN   = 8'b0010_0000,
    S_PUT  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

endpackage

[hw/rtl/efsa_channels.sv]
// Valid/ready channel interfaces for input items and result items
interface efsa_feed_if;
  import efsa_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_BITS-1:0] server_index;
  logic [AMT_BITS-1:0] amount;

  modport source(output valid, mode, server_index, amount, input ready);
  modport sink(input valid, mode, server_index, amount, output ready);
endinterface

interface efsa_result_if;
  import efsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_BITS-1:0]      assigned_server;
  logic [OUT_TIME_BITS-1:0] finish_time;
  logic [OUT_TIME_BITS-1:0] makespan;
  logic                     is_assignment;

  modport source(output valid, assigned_server, finish_time, makespan, is_assignment,
                 input ready);
  modport sink(input valid, assigned_server, finish_time, makespan, is_assignment,
               output ready);
endinterface

[hw/rtl/efsa_ram.sv]
// Generic single-write, single-read RAM with registered read data
module efsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/earliest_free_server_assigner_unit.sv]
// Greedy list scheduler: assigns each customer item to the earliest free server
//
// Channels: feed takes items (mode 0 loads server_index's time per unit from
// amount, mode 1 assigns a customer of amount units); result gives one item per
// input item with the server, its new finish time and the running makespan.
// cfg_we/cfg_wdata write cashier_count; the user must do this only while the
// block is idle, which the block does not enforce. Servers sit in a binary
// min-heap on (finish time, server index) held in two mirrored RAMs, so both
// children of a node are read in the same cycle. A load passes straight to
// S_FIN, which puts its result in the output register. A customer reads the
// top (unless it fills a new server), reads the rate, multiplies, does a
// saturating add, then one read-compare-write per heap level walked by the
// sift (at most ceil(log2(MAX_SERVERS)) levels).
// feed.ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next item is accepted and processed, and the
// sequencer holds in its last state if that register is still full.
// Reset empties the heap, clears the makespan, sets cashier_count to 1 and
// drops result.valid; RAM contents are not cleared and need no clearing pass.
module earliest_free_server_assigner_unit #(
  parameter int MAX_SERVERS = 64,
  parameter int TIME_BITS   = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [efsa_pkg::CNT_BITS-1:0] cfg_wdata,
  efsa_feed_if.sink                     feed,
  efsa_result_if.source                 result
);
  import efsa_pkg::*;

  localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int FILL_W = IDX_W + 1;
  localparam int PW     = IDX_W + 2;
  localparam int EW     = (FILL_W > CNT_BITS) ? FILL_W : CNT_BITS;
  localparam int ENT_W  = TIME_BITS + IDX_W;
  localparam int PROD_W = 2 * AMT_BITS;
  localparam int SUM_W  = ((TIME_BITS > PROD_W) ? TIME_BITS : PROD_W) + 1;

  // control state
  state_t              state;
  logic [CNT_BITS-1:0] cashier_count;
  logic [FILL_W-1:0]   heap_fill;
  logic [TIME_BITS-1:0] max_finish;

  // datapath registers
  logic                     is_fill;
  logic [AMT_BITS-1:0]      amount_q;
  logic [IDX_W-1:0]         held_srv;
  logic [TIME_BITS-1:0]     held_fin;
  logic [IDX_W-1:0]         pos;
  logic [PROD_W-1:0]        prod;
  logic [IDX_BITS-1:0]      res_srv;
  logic [OUT_TIME_BITS-1:0] res_fin;
  logic [OUT_TIME_BITS-1:0] res_max;
  logic                     res_asg;

  logic                 accept;
  logic [IDX_W-1:0]     fill_idx;
  logic [EW-1:0]        cc_w;
  logic [EW-1:0]        max_w;
  logic [EW-1:0]        eff_count;
  logic                 fill_now;
  logic [IDX_W+IDX_BITS-1:0] sidx_wide;
  logic                 load_ok;

  logic                 rate_we;
  logic [IDX_W-1:0]     rate_raddr;
  logic [AMT_BITS-1:0]  rate_rd;

  logic                 heap_we;
  logic [IDX_W-1:0]     heap_waddr;
  logic [ENT_W-1:0]     heap_wdata;
  logic [IDX_W-1:0]     heap_raddr_a;
  logic [IDX_W-1:0]     heap_raddr_b;
  logic [ENT_W-1:0]     rd_a;
  logic [ENT_W-1:0]     rd_b;
  logic [ENT_W-1:0]     held;

  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     tmax_w;
  logic [TIME_BITS-1:0] fin_new;
  logic [TIME_BITS-1:0] max_new;
  logic [IDX_W+IDX_BITS-1:0] srv_wide;
  logic [TIME_BITS+OUT_TIME_BITS-1:0] fin_wide;
  logic [TIME_BITS+OUT_TIME_BITS-1:0] max_new_wide;
  logic [TIME_BITS+OUT_TIME_BITS-1:0] max_cur_wide;

  logic [PW-1:0]        fill_p;
  logic [PW-1:0]        cl;
  logic [PW-1:0]        cr;
  logic                 use_r;
  logic [ENT_W-1:0]     cand;
  logic [IDX_W-1:0]     cidx;
  logic                 move_dn;
  logic [IDX_W-1:0]     dn_base;
  logic [PW-1:0]        nl;
  logic [PW-1:0]        nr;
  logic                 nl_ok;
  logic [IDX_W-1:0]     par;
  logic                 move_up;
  logic [IDX_W-1:0]     up_base;
  logic [IDX_W-1:0]     up_par;

  assign feed.ready = (state == S_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign fill_idx   = heap_fill[IDX_W-1:0];

  // cashier_count of zero acts as one, above capacity acts as capacity
  assign cc_w      = EW'(cashier_count);
  assign max_w     = EW'(MAX_SERVERS);
  assign eff_count = (cashier_count == '0) ? EW'(1) : ((cc_w > max_w) ? max_w : cc_w);
  assign fill_now  = EW'(heap_fill) < eff_count;

  assign sidx_wide = {{IDX_W{1'b0}}, feed.server_index};
  assign load_ok   = sidx_wide < (IDX_W + IDX_BITS)'(MAX_SERVERS);

  // rate table
  assign rate_we    = accept && (feed.mode == MODE_LOAD) && load_ok;
  assign rate_raddr = (state == S_TOP) ? rd_a[IDX_W-1:0] : fill_idx;

  efsa_ram #(.WIDTH(AMT_BITS), .DEPTH(MAX_SERVERS)) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (sidx_wide[IDX_W-1:0]),
    .wdata (feed.amount),
    .raddr (rate_raddr),
    .rdata (rate_rd)
  );

  // heap entries pack {finish, server}, so an unsigned compare orders the keys
  efsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SERVERS)) u_heap_ram_a (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr_a),
    .rdata (rd_a)
  );

  efsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SERVERS)) u_heap_ram_b (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr_b),
    .rdata (rd_b)
  );

  assign held = {held_fin, held_srv};

  // saturating finish time update
  assign sum     = SUM_W'(held_fin) + SUM_W'(prod);
  assign tmax_w  = SUM_W'({TIME_BITS{1'b1}});
  assign fin_new = (sum > tmax_w) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign max_new = (fin_new > max_finish) ? fin_new : max_finish;

  assign srv_wide     = {{IDX_BITS{1'b0}}, held_srv};
  assign fin_wide     = {{OUT_TIME_BITS{1'b0}}, fin_new};
  assign max_new_wide = {{OUT_TIME_BITS{1'b0}}, max_new};
  assign max_cur_wide = {{OUT_TIME_BITS{1'b0}}, max_finish};

  // sift-down: hole at pos, pick the smaller child, move it up if below held
  assign fill_p  = PW'(heap_fill);
  assign cl      = {1'b0, pos, 1'b1};
  assign cr      = cl + PW'(1);
  assign use_r   = (cr < fill_p) && (rd_b < rd_a);
  assign cand    = use_r ? rd_b : rd_a;
  assign cidx    = use_r ? cr[IDX_W-1:0] : cl[IDX_W-1:0];
  assign move_dn = cand < held;
  assign dn_base = (state == S_ADD) ? '0 : cidx;
  assign nl      = {1'b0, dn_base, 1'b1};
  assign nr      = nl + PW'(1);
  assign nl_ok   = nl < fill_p;

  // sift-up: hole at pos, pull the parent down if held is below it
  assign par     = (pos - IDX_W'(1)) >> 1;
  assign move_up = held < rd_a;
  assign up_base = (state == S_ADD) ? fill_idx : par;
  assign up_par  = (up_base - IDX_W'(1)) >> 1;

  // in the sift states, read addresses never hit the entry written in the same cycle
  always_comb begin
    heap_raddr_a = '0;
    heap_raddr_b = nr[IDX_W-1:0];
    case (state)
      S_ADD: begin
        heap_raddr_a = is_fill ? up_par : nl[IDX_W-1:0];
      end
      S_UP: begin
        heap_raddr_a = up_par;
      end
      S_DN: begin
        heap_raddr_a = nl[IDX_W-1:0];
      end
      default: begin
        heap_raddr_a = '0;
      end
    endcase
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = held;
    case (state)
      S_UP: begin
        heap_we    = 1'b1;
        heap_wdata = move_up ? rd_a : held;
      end
      S_DN: begin
        heap_we    = 1'b1;
        heap_wdata = move_dn ? cand : held;
      end
      S_PUT: begin
        heap_we    = 1'b1;
      end
      default: begin
        heap_we    = 1'b0;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cashier_count <= CNT_BITS'(1);
      heap_fill     <= '0;
      max_finish    <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cashier_count <= cfg_wdata;
      end
      // S_FIN refills the output register itself
      if (result.valid && result.ready && (state != S_FIN)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (feed.mode == MODE_LOAD) begin
              state <= S_FIN;
            end else if (fill_now) begin
              state <= S_MUL;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_TOP: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          max_finish <= max_new;
          if (is_fill) begin
            heap_fill <= heap_fill + FILL_W'(1);
            state     <= (fill_idx == '0) ? S_PUT : S_UP;
          end else begin
            state <= nl_ok ? S_DN : S_PUT;
          end
        end
        S_UP: begin
          if (move_up) begin
            state <= (par == '0) ? S_PUT : S_UP;
          end else begin
            state <= S_FIN;
          end
        end
        S_DN: begin
          if (move_dn) begin
            state <= nl_ok ? S_DN : S_PUT;
          end else begin
            state <= S_FIN;
          end
        end
        S_PUT: begin
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          amount_q <= feed.amount;
          is_fill  <= fill_now;
          if (feed.mode == MODE_LOAD) begin
            res_srv <= feed.server_index;
            res_fin <= '0;
            res_max <= max_cur_wide[OUT_TIME_BITS-1:0];
            res_asg <= 1'b0;
          end else begin
            held_srv <= fill_idx;
            held_fin <= '0;
          end
        end
      end
      S_TOP: begin
        held_fin <= rd_a[ENT_W-1:IDX_W];
        held_srv <= rd_a[IDX_W-1:0];
      end
      S_MUL: begin
        prod <= PROD_W'(rate_rd) * PROD_W'(amount_q);
      end
      S_ADD: begin
        held_fin <= fin_new;
        res_srv  <= srv_wide[IDX_BITS-1:0];
        res_fin  <= fin_wide[OUT_TIME_BITS-1:0];
        res_max  <= max_new_wide[OUT_TIME_BITS-1:0];
        res_asg  <= 1'b1;
        pos      <= is_fill ? fill_idx : '0;
      end
      S_UP: begin
        if (move_up) begin
          pos <= par;
        end
      end
      S_DN: begin
        if (move_dn) begin
          pos <= cidx;
        end
      end
      S_FIN: begin
        if (!result.valid || result.ready) begin
          result.assigned_server <= res_srv;
          result.finish_time     <= res_fin;
          result.makespan        <= res_max;
          result.is_assignment   <= res_asg;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

endmodule

[hw/rtl/efsa_checker.sv]
// Port-level checker for the server assigner and its bind to the top level
`include "earliest_free_server_assigner_unit_defines.svh"

module efsa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [efsa_pkg::IDX_BITS-1:0]      out_srv,
  input logic [efsa_pkg::OUT_TIME_BITS-1:0] out_fin,
  input logic [efsa_pkg::OUT_TIME_BITS-1:0] out_span,
  input logic                               out_asg
);
  import efsa_pkg::*;

  `EFSA_ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")

  `EFSA_ASSERT_CLK(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_srv) && $stable(out_fin) && $stable(out_span) && $stable(out_asg), "stalled result item changed")

  `EFSA_ASSERT_CLK(a_span_covers, clk, rst, out_valid && out_asg |-> out_span >= out_fin, "makespan below finish time")

  `EFSA_ASSERT_CLK(a_min_latency, clk, rst, $rose(out_valid) |-> !$past(in_valid && in_ready), "result item one cycle after acceptance")

  `EFSA_ASSERT_ALL(a_reset_empty, clk, $past(rst) |-> !out_valid, "result item right after reset")

endmodule

bind earliest_free_server_assigner_unit efsa_checker u_efsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (feed.valid),
  .in_ready  (feed.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_srv   (result.assigned_server),
  .out_fin   (result.finish_time),
  .out_span  (result.makespan),
  .out_asg   (result.is_assignment)
);

[tb/earliest_free_server_assigner_unit_tb.sv]
// Testbench for the earliest-free server assigner: directed table, random items, self-check
`timescale 1ns / 1ps

module earliest_free_server_assigner_unit_tb;
  import efsa_pkg::*;

  localparam int SERVERS      = 64;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int PLAN_ROWS    = 25;

  typedef struct packed {
    logic [IDX_BITS-1:0]      server;
    logic [OUT_TIME_BITS-1:0] finish;
    logic [OUT_TIME_BITS-1:0] span;
    logic                     assigned;
  } outcome_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_CUST
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [IDX_BITS-1:0] idx;
    logic [AMT_BITS-1:0] amt;
    logic [CNT_BITS-1:0] count;
    logic [16:0]         reps;
    logic                typed;
    outcome_t            want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CNT_BITS-1:0] cfg_wdata;

  efsa_feed_if   feed_ch();
  efsa_result_if res_ch();

  earliest_free_server_assigner_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .feed     (feed_ch),
    .result   (res_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the scheduler state
  logic [AMT_BITS-1:0]      rate_tbl [SERVERS];
  logic [OUT_TIME_BITS-1:0] heap_time[SERVERS];
  logic [IDX_BITS-1:0]      heap_id  [SERVERS];
  int unsigned              fill_level  = 0;
  logic [OUT_TIME_BITS-1:0] span_so_far = '0;
  logic [CNT_BITS-1:0]      staffed     = 7'd1;

  outcome_t pending_results[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  // Shared between the stimulus and the receiver
  bit quiet          = 1'b0;
  bit want_long_hold = 1'b0;

  // Sender burst state
  int unsigned burst_left = 0;

  // Receiver stall state
  int unsigned hold_left      = 0;
  int unsigned run_left       = 0;
  int unsigned stall_style    = 0;
  bit          long_hold_done = 1'b0;

  row_t plan[PLAN_ROWS];

  function automatic bit slot_before(input int unsigned a, input int unsigned b);
    if (heap_time[a] != heap_time[b]) return heap_time[a] < heap_time[b];
    return heap_id[a] < heap_id[b];
  endfunction

  function automatic void slot_swap(input int unsigned a, input int unsigned b);
    logic [OUT_TIME_BITS-1:0] t;
    logic [IDX_BITS-1:0]      s;
    t = heap_time[a];
    s = heap_id[a];
    heap_time[a] = heap_time[b];
    heap_id[a]   = heap_id[b];
    heap_time[b] = t;
    heap_id[b]   = s;
  endfunction

  // Clamp at the top of the time range
  function automatic logic [OUT_TIME_BITS-1:0] sat_sum(input logic [OUT_TIME_BITS-1:0] base,
                                                       input logic [31:0] prod);
    logic [OUT_TIME_BITS:0] s;
    s = {1'b0, base} + prod;
    return s[OUT_TIME_BITS] ? '1 : s[OUT_TIME_BITS-1:0];
  endfunction

  function automatic outcome_t schedule_item(input logic mode, input logic [IDX_BITS-1:0] idx,
                                             input logic [AMT_BITS-1:0] amt);
    outcome_t                 o;
    int unsigned              lim, pos, parent, lc, rc, best;
    logic [IDX_BITS-1:0]      srv;
    logic [OUT_TIME_BITS-1:0] fin;
    bit                       settled;
    if (mode == MODE_LOAD) begin
      rate_tbl[idx] = amt;
      o = '{idx, '0, span_so_far, 1'b0};
      return o;
    end
    lim = (staffed == 0) ? 1 : ((staffed > SERVERS) ? SERVERS : staffed);
    settled = 1'b0;
    if (fill_level < lim) begin
      // fill the next server, then sift it up
      srv = IDX_BITS'(fill_level);
      fin = sat_sum('0, {16'b0, rate_tbl[srv]} * {16'b0, amt});
      pos = fill_level;
      heap_time[pos] = fin;
      heap_id[pos]   = srv;
      fill_level++;
      while (pos > 0 && !settled) begin
        parent = (pos - 1) / 2;
        if (slot_before(pos, parent)) begin
          slot_swap(pos, parent);
          pos = parent;
        end else begin
          settled = 1'b1;
        end
      end
    end else begin
      // extend the earliest server, then sift the top down
      srv = heap_id[0];
      fin = sat_sum(heap_time[0], {16'b0, rate_tbl[srv]} * {16'b0, amt});
      heap_time[0] = fin;
      pos = 0;
      while (!settled) begin
        lc   = 2 * pos + 1;
        rc   = lc + 1;
        best = pos;
        if (lc < fill_level && slot_before(lc, best)) best = lc;
        if (rc < fill_level && slot_before(rc, best)) best = rc;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          slot_swap(pos, best);
          pos = best;
        end
      end
    end
    if (fin > span_so_far) span_so_far = fin;
    o = '{srv, fin, span_so_far, 1'b1};
    return o;
  endfunction

  // Lean toward zero, one and the maximum so ties and saturation show up
  function automatic logic [AMT_BITS-1:0] skewed_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'd1;
      2: return AMT_BITS'($urandom_range(2, 8));
      3: return '1;
      default: return AMT_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic offer_item(input logic mode, input logic [IDX_BITS-1:0] idx,
                            input logic [AMT_BITS-1:0] amt, input bit typed,
                            input outcome_t want);
    outcome_t    predicted;
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap != 0) begin
      feed_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed_ch.valid        <= 1'b1;
    feed_ch.mode         <= mode;
    feed_ch.server_index <= idx;
    feed_ch.amount       <= amt;
    do @(posedge clk); while (!feed_ch.ready);
    predicted = schedule_item(mode, idx, amt);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Write cashier_count once the block has drained and sits idle
  task automatic set_staffing(input logic [CNT_BITS-1:0] v);
    feed_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (!feed_ch.ready) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    staffed = v;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall styles in runs, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = 400;
      res_ch.ready <= 1'b0;
    end else if (quiet) begin
      res_ch.ready <= 1'b1;
    end else begin
      if (run_left == 0) begin
        stall_style = $urandom_range(0, 3);
        run_left    = $urandom_range(1, 40);
      end else begin
        run_left--;
      end
      case (stall_style)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default: res_ch.ready <= (cycle_count[2:0] != 3'd0);
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.assigned_server, res_ch.finish_time, res_ch.makespan,
              res_ch.is_assignment};
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("cycle %0d: result item with nothing pending", cycle_count);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.server !== want.server || got.finish !== want.finish ||
            got.span !== want.span || got.assigned !== want.assigned) begin
          if (fault_count < 10)
            $display("cycle %0d: exp srv %0d fin %0h span %0h asg %0b, got srv %0d fin %0h span %0h asg %0b",
                     cycle_count, want.server, want.finish, want.span, want.assigned,
                     got.server, got.finish, got.span, got.assigned);
          fault_count++;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run_len;
    logic [CNT_BITS-1:0] cnt;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    feed_ch.valid        = 1'b0;
    feed_ch.mode         = MODE_LOAD;
    feed_ch.server_index = '0;
    feed_ch.amount       = '0;
    res_ch.ready         = 1'b0;

    // kind, index, amount, count, repeats, typed, expected
    plan = '{
      '{ROW_LOAD, 6'd0,  16'hFFFF, 7'd0, 17'd1, 1'b1, '{6'd0,  48'd0, 48'd0, 1'b0}},
      '{ROW_LOAD, 6'd63, 16'h0000, 7'd0, 17'd1, 1'b1, '{6'd63, 48'd0, 48'd0, 1'b0}},
      '{ROW_LOAD, 6'd1,  16'h0001, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_LOAD, 6'd2,  16'h5555, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_LOAD, 6'd3,  16'hAAAA, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_LOAD, 6'd4,  16'h0002, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0000, 7'd0, 17'd1, 1'b1, '{6'd0, 48'd0, 48'd0, 1'b1}},
      '{ROW_CUST, 6'd0,  16'hFFFF, 7'd0, 17'd1, 1'b1,
        '{6'd0, 48'hFFFE_0001, 48'hFFFE_0001, 1'b1}},
      // pile the largest customers onto server 0
      '{ROW_CUST, 6'd21, 16'hFFFF, 7'd0, 17'd40, 1'b0, '0},
      '{ROW_CUST, 6'd42, 16'hFFFF, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_LOAD, 6'd5,  16'h0007, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CFG,  6'd0,  16'h0000, 7'd0, 17'd0, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0001, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CFG,  6'd0,  16'h0000, 7'd3, 17'd0, 1'b0, '0},
      '{ROW_CUST, 6'd63, 16'h0007, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0002, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0003, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CFG,  6'd0,  16'h0000, 7'd127, 17'd0, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0001, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0005, 7'd0, 17'd1, 1'b0, '0},
      // lower the count below the number of servers already in the heap
      '{ROW_CFG,  6'd0,  16'h0000, 7'd2, 17'd0, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0000, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0004, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CUST, 6'd0,  16'h0001, 7'd0, 17'd1, 1'b0, '0},
      '{ROW_CFG,  6'd0,  16'h0000, 7'd64, 17'd0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        set_staffing(plan[r].count);
      end else begin
        quiet = (plan[r].reps > 1);
        repeat (plan[r].reps)
          offer_item((plan[r].kind == ROW_CUST) ? MODE_CUST : MODE_LOAD, plan[r].idx,
                     plan[r].amt, plan[r].typed, plan[r].want);
        quiet = 1'b0;
      end
    end

    // every rate is written before any new server can be filled
    for (int s = 0; s < SERVERS; s++)
      offer_item(MODE_LOAD, IDX_BITS'(s), skewed_value(), 1'b0, '0);
    sent = SERVERS;

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd64;
        3: cnt = CNT_BITS'($urandom_range(65, 127));
        default: cnt = CNT_BITS'($urandom_range(2, 63));
      endcase
      set_staffing(cnt);
      quiet = ($urandom_range(0, 4) == 0);
      if (sent > 600) want_long_hold = 1'b1;
      run_len = $urandom_range(20, 80);
      repeat (run_len) begin
        if ($urandom_range(0, 3) == 0)
          offer_item(MODE_LOAD, IDX_BITS'($urandom_range(0, 63)), skewed_value(), 1'b0, '0);
        else
          offer_item(MODE_CUST, IDX_BITS'($urandom), skewed_value(), 1'b0, '0);
        sent++;
      end
    end
    quiet = 1'b0;

    feed_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/efsa_pkg.sv
hw/rtl/efsa_channels.sv
hw/rtl/efsa_ram.sv
hw/rtl/earliest_free_server_assigner_unit.sv
hw/rtl/efsa_checker.sv
tb/earliest_free_server_assigner_unit_tb.sv
